/* rtl/pfec_pkg.sv */
// ----------------------------------------------------------------------------
// pfec_pkg
// Shared types, constants and fixed-point helpers for the Phoenix
// escape-time counter.
// ----------------------------------------------------------------------------
package pfec_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;
    localparam int MUL_BITS   = 2 * WORD_BITS;
    localparam int Q_BITS     = MUL_BITS - FRAC_BITS;
    localparam int THR_BITS   = 31;
    localparam int FB_BITS    = 30;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic        [WORD_BITS-1:0] umag_t;
    typedef logic        [MUL_BITS-1:0]  prod_t;
    typedef logic signed [WORD_BITS:0]   wide_t;
    typedef logic        [COUNT_BITS-1:0] count_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_MAX_ITER  = 2'd1,
        REG_FB_REAL   = 2'd2,
        REG_FB_IMAG   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM1,
        ST_SUM2,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [THR_BITS-1:0]      threshold;
        count_t                   limit;
        logic signed [FB_BITS-1:0] fb_real;
        logic signed [FB_BITS-1:0] fb_imag;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum1;
        logic sum2;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic start_run;
        logic run_more;
        logic out_free;
    } status_t;

    function automatic umag_t mag(input word_t a);
        umag_t r;
        r = a[WORD_BITS-1] ? umag_t'(-a) : umag_t'(a);
        return r;
    endfunction

    function automatic word_t sat_sum(input wide_t s);
        word_t r;
        if (s > wide_t'(WORD_MAX))
            r = WORD_MAX;
        else if (s < wide_t'(WORD_MIN))
            r = WORD_MIN;
        else
            r = s[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic wide_t widen(input word_t a);
        wide_t r;
        r = {a[WORD_BITS-1], a};
        return r;
    endfunction

    // Product magnitude to saturated fixed point, truncated toward zero
    function automatic word_t fx_sat(input prod_t m, input logic neg);
        logic [Q_BITS-1:0] q;
        word_t             r;
        q = m[MUL_BITS-1:FRAC_BITS];
        if (neg) begin
            if (q > {{(Q_BITS-WORD_BITS){1'b0}}, WORD_MIN})
                r = WORD_MIN;
            else
                r = -word_t'(q[WORD_BITS-1:0]);
        end else begin
            if (q > {{(Q_BITS-WORD_BITS){1'b0}}, WORD_MAX})
                r = WORD_MAX;
            else
                r = word_t'(q[WORD_BITS-1:0]);
        end
        return r;
    endfunction

endpackage

/* rtl/phoenix_fractal_escape_count.sv */
// ----------------------------------------------------------------------------
// phoenix_fractal_escape_count
// Escape-time counter for the Phoenix recurrence on one Q4.28 point.
// ----------------------------------------------------------------------------
// Each recurrence step runs multiply, then first sums, then final sums.
// One point is in flight at a time; the next point is taken while the
// result waits in the output register.
// Reset: clears sequencer and output valid; config registers return to defaults.
// ----------------------------------------------------------------------------
module phoenix_fractal_escape_count (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pfec_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [pfec_pkg::DATA_BITS-1:0]        pwdata,
    output logic [pfec_pkg::DATA_BITS-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [31:0]                    c_real,
    input  logic signed [31:0]                    c_imag,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [15:0]                           iteration_count
);

    logic [pfec_pkg::THR_BITS-1:0]       thr_reg;
    logic [15:0]                         maxit_reg;
    logic signed [pfec_pkg::FB_BITS-1:0] fbr_reg;
    logic signed [pfec_pkg::FB_BITS-1:0] fbi_reg;

    logic               wr_en;
    pfec_pkg::reg_idx_t wr_idx;
    pfec_pkg::cfg_t     cfg;
    pfec_pkg::cmd_t     cmd;
    pfec_pkg::status_t  status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = pfec_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= 31'd1073741824;
            maxit_reg <= 16'd256;
            fbr_reg   <= -30'sd131533373;
            fbi_reg   <= 30'sd56371446;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                pfec_pkg::REG_THRESHOLD: thr_reg   <= pwdata[pfec_pkg::THR_BITS-1:0];
                pfec_pkg::REG_MAX_ITER:  maxit_reg <= pwdata[15:0];
                pfec_pkg::REG_FB_REAL:   fbr_reg   <= pwdata[pfec_pkg::FB_BITS-1:0];
                pfec_pkg::REG_FB_IMAG:   fbi_reg   <= pwdata[pfec_pkg::FB_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            pfec_pkg::REG_THRESHOLD: prdata = {1'b0, thr_reg};
            pfec_pkg::REG_MAX_ITER:  prdata = {16'd0, maxit_reg};
            pfec_pkg::REG_FB_REAL:   prdata = {2'd0, fbr_reg};
            pfec_pkg::REG_FB_IMAG:   prdata = {2'd0, fbi_reg};
            default:                 prdata = '0;
        endcase
    end

    assign cfg.threshold = thr_reg;
    assign cfg.limit     = maxit_reg;
    assign cfg.fb_real   = fbr_reg;
    assign cfg.fb_imag   = fbi_reg;

    pfec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pfec_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg             (cfg),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .iteration_count (iteration_count)
    );

endmodule

/* rtl/pfec_ctrl.sv */
// ----------------------------------------------------------------------------
// pfec_ctrl
// Sequencer: load, then multiply / sum / sum per iteration (none if threshold or limit is zero), then deliver.
// ----------------------------------------------------------------------------
module pfec_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pfec_pkg::status_t  status,
    output pfec_pkg::cmd_t     cmd
);

    pfec_pkg::state_t state_reg;
    pfec_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfec_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfec_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.start_run ? pfec_pkg::ST_MUL : pfec_pkg::ST_FINISH;
            end
            pfec_pkg::ST_MUL:  state_next = pfec_pkg::ST_SUM1;
            pfec_pkg::ST_SUM1: state_next = pfec_pkg::ST_SUM2;
            pfec_pkg::ST_SUM2:
            begin
                state_next = status.run_more ? pfec_pkg::ST_MUL : pfec_pkg::ST_FINISH;
            end
            pfec_pkg::ST_FINISH:
            begin
                if (status.out_free)
                    state_next = pfec_pkg::ST_IDLE;
            end
            default: state_next = pfec_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            pfec_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            pfec_pkg::ST_MUL:    cmd.mul    = 1'b1;
            pfec_pkg::ST_SUM1:   cmd.sum1   = 1'b1;
            pfec_pkg::ST_SUM2:   cmd.sum2   = 1'b1;
            pfec_pkg::ST_FINISH: cmd.finish = status.out_free;
            default:             in_stall   = 1'b1;
        endcase
    end

endmodule

/* rtl/pfec_dp.sv */
// ----------------------------------------------------------------------------
// pfec_dp
// Recurrence datapath: five parallel multipliers, two saturating sum
// stages, iteration counter and the output register.
// ----------------------------------------------------------------------------
module pfec_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pfec_pkg::cmd_t           cmd,
    output pfec_pkg::status_t        status,
    input  pfec_pkg::cfg_t           cfg,
    input  pfec_pkg::word_t          c_real,
    input  pfec_pkg::word_t          c_imag,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [15:0]              iteration_count
);

    pfec_pkg::word_t  cr_reg, ci_reg;
    pfec_pkg::word_t  x_reg, y_reg, xp_reg, yp_reg;
    pfec_pkg::word_t  r_reg;
    pfec_pkg::count_t n_reg;

    pfec_pkg::prod_t  pxx_reg, pyy_reg, pxy_reg, pfr_reg, pfi_reg;
    logic             nxy_reg, nfr_reg, nfi_reg;

    pfec_pkg::word_t  are_reg, aim_reg, fr_reg, fi_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      count_out_reg;

    pfec_pkg::word_t  pr, pi;
    pfec_pkg::word_t  sx2, sy2, sxy;
    pfec_pkg::word_t  re_part, im_part;

    assign pr = pfec_pkg::word_t'(cfg.fb_real);
    assign pi = pfec_pkg::word_t'(cfg.fb_imag);

    assign sx2 = pfec_pkg::fx_sat(pxx_reg, 1'b0);
    assign sy2 = pfec_pkg::fx_sat(pyy_reg, 1'b0);
    assign sxy = pfec_pkg::fx_sat(pxy_reg, nxy_reg);

    assign re_part = pfec_pkg::sat_sum(pfec_pkg::widen(are_reg) + pfec_pkg::widen(cr_reg));
    assign im_part = pfec_pkg::sat_sum(pfec_pkg::widen(aim_reg) + pfec_pkg::widen(ci_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
            x_reg  <= '0;
            y_reg  <= '0;
            xp_reg <= '0;
            yp_reg <= '0;
            r_reg  <= '0;
            n_reg  <= '0;
        end
        if (cmd.mul)
        begin
            pxx_reg <= pfec_pkg::prod_t'(pfec_pkg::mag(x_reg))
                       * pfec_pkg::prod_t'(pfec_pkg::mag(x_reg));
            pyy_reg <= pfec_pkg::prod_t'(pfec_pkg::mag(y_reg))
                       * pfec_pkg::prod_t'(pfec_pkg::mag(y_reg));
            pxy_reg <= pfec_pkg::prod_t'(pfec_pkg::mag(x_reg))
                       * pfec_pkg::prod_t'(pfec_pkg::mag(y_reg));
            pfr_reg <= pfec_pkg::prod_t'(pfec_pkg::mag(pr))
                       * pfec_pkg::prod_t'(pfec_pkg::mag(xp_reg));
            pfi_reg <= pfec_pkg::prod_t'(pfec_pkg::mag(pi))
                       * pfec_pkg::prod_t'(pfec_pkg::mag(yp_reg));
            nxy_reg <= x_reg[pfec_pkg::WORD_BITS-1] ^ y_reg[pfec_pkg::WORD_BITS-1];
            nfr_reg <= pr[pfec_pkg::WORD_BITS-1] ^ xp_reg[pfec_pkg::WORD_BITS-1];
            nfi_reg <= pi[pfec_pkg::WORD_BITS-1] ^ yp_reg[pfec_pkg::WORD_BITS-1];
        end
        if (cmd.sum1)
        begin
            are_reg <= pfec_pkg::sat_sum(pfec_pkg::widen(sx2) - pfec_pkg::widen(sy2));
            aim_reg <= pfec_pkg::sat_sum(pfec_pkg::widen(sxy) + pfec_pkg::widen(sxy));
            r_reg   <= pfec_pkg::sat_sum(pfec_pkg::widen(sx2) + pfec_pkg::widen(sy2));
            fr_reg  <= pfec_pkg::fx_sat(pfr_reg, nfr_reg);
            fi_reg  <= pfec_pkg::fx_sat(pfi_reg, nfi_reg);
            n_reg   <= n_reg + pfec_pkg::count_t'(1);
        end
        if (cmd.sum2)
        begin
            x_reg  <= pfec_pkg::sat_sum(pfec_pkg::widen(re_part) + pfec_pkg::widen(fr_reg));
            y_reg  <= pfec_pkg::sat_sum(pfec_pkg::widen(im_part) + pfec_pkg::widen(fi_reg));
            xp_reg <= x_reg;
            yp_reg <= y_reg;
        end
        if (cmd.finish)
            count_out_reg <= n_reg[15:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.start_run = (cfg.threshold != '0) && (cfg.limit != '0);
    assign status.run_more  = (r_reg < pfec_pkg::word_t'({1'b0, cfg.threshold}))
                              && (n_reg < cfg.limit);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign iteration_count = count_out_reg;

endmodule

/* rtl/pfec_checker.sv */
// ----------------------------------------------------------------------------
// pfec_checker
// Port-level checks on the escape counter's transaction behavior.
// ----------------------------------------------------------------------------
module pfec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] iteration_count
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(iteration_count))
        else $error("result changed while stalled");

    // one point in flight: busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second point taken while busy");

    // a new result comes with the input side free again
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result produced but input still stalled");

endmodule

bind phoenix_fractal_escape_count pfec_checker u_pfec_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .iteration_count (iteration_count)
);
